[sv/ffa_pkg.sv]
package ffa_pkg;

    localparam int MaxRegions = 16;
    localparam logic [15:0] DefaultUnits = 16'd1000;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_DEFRAG = 2'd2,
        FUNC_INIT   = 2'd3
    } func_t;

    localparam logic [3:0] STS_SPLIT     = 4'd0;
    localparam logic [3:0] STS_EXACT     = 4'd1;
    localparam logic [3:0] STS_BAD_SIZE  = 4'd2;
    localparam logic [3:0] STS_NO_FIT    = 4'd3;
    localparam logic [3:0] STS_FREED     = 4'd4;
    localparam logic [3:0] STS_NO_OWNER  = 4'd5;
    localparam logic [3:0] STS_DEFRAG    = 4'd6;
    localparam logic [3:0] STS_DEF_EMPTY = 4'd7;
    localparam logic [3:0] STS_FULL      = 4'd8;
    localparam logic [3:0] STS_INIT      = 4'd9;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        owner_id;
        logic signed [15:0] request_size;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] region_address;
        logic [15:0] region_size;
    } rsp_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] owner;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_RIGHT = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_LOAD  = 2'd3
    } cell_op_t;

    typedef enum logic [2:0] {
        LIST_HOLD = 3'd0,
        LIST_ROT  = 3'd1,
        LIST_DROP = 3'd2,
        LIST_PUSH = 3'd3,
        LIST_SET  = 3'd4
    } list_op_t;

    typedef struct packed {
        list_op_t op;
        entry_t   data;
        logic     set_one;
    } list_ctl_t;

endpackage

[sv/first_fit_allocator_with_compaction.sv]
// Channel  | Ports                         | Payload
// ---------+-------------------------------+--------------------------------
// command  | s_valid s_ready s_data        | func, owner_id, request_size
// result   | m_valid m_ready m_data        | status, region_address, region_size
// config   | cfg_valid cfg_ready cfg_data  | memory_units
//
// One command at a time: accept, then a pass over each entry of the scanned list
// (free list for allocate, allocated list for free and defrag), then a commit;
// init, rejected commands and commands on an empty list skip the pass.
// The pass rotates the scanned list through its chain of list cells.
// Reset leaves one free region of 1000 units at address 0.
// A commit waits while the previous result is held on m_data.
module first_fit_allocator_with_compaction #(
    parameter int MAX_REGIONS = ffa_pkg::MaxRegions
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ffa_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ffa_pkg::rsp_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);
    import ffa_pkg::*;

    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam entry_t FreeRst = '{start: 16'd0, length: DefaultUnits, owner: 16'd0};

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PASS   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    func_t         func_reg, func_next;
    logic [15:0]   pid_reg, pid_next;
    logic [15:0]   raw_reg, raw_next;
    logic [CW-1:0] step_reg, step_next;
    logic          found_reg, found_next;
    logic          full_reg, full_next;
    logic          early_reg, early_next;
    logic [3:0]    early_sts_reg, early_sts_next;
    logic [15:0]   fnd_start_reg, fnd_start_next;
    logic [15:0]   fnd_len_reg, fnd_len_next;
    logic [15:0]   pos_reg, pos_next;
    logic [15:0]   spare_reg, spare_next;
    logic [15:0]   total_reg, total_next;
    logic [15:0]   units_reg;
    logic          m_valid_reg, m_valid_next;
    rsp_t          m_data_reg, m_data_next;

    list_ctl_t     free_ctl, alloc_ctl;
    entry_t        free_top, alloc_head, head;
    logic [CW-1:0] free_cnt, alloc_cnt;
    logic          table_full;
    logic [15:0]   raw_in;
    logic [15:0]   spare_in;

    ffa_list #(
        .MAX_REGIONS(MAX_REGIONS),
        .RST_ONE    (1'b1),
        .RST_ENTRY  (FreeRst)
    ) u_free (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (free_ctl),
        .head   (free_top),
        .count  (free_cnt)
    );

    ffa_list #(
        .MAX_REGIONS(MAX_REGIONS),
        .RST_ONE    (1'b0),
        .RST_ENTRY  ('0)
    ) u_alloc (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (alloc_ctl),
        .head   (alloc_head),
        .count  (alloc_cnt)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign head       = (func_reg == FUNC_ALLOC) ? free_top : alloc_head;
    assign table_full = ({1'b0, free_cnt} + {1'b0, alloc_cnt}) >= (CW+1)'(MAX_REGIONS);
    assign raw_in     = s_data.request_size;
    assign spare_in   = (total_reg < units_reg) ? units_reg - total_reg : 16'd0;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        pid_next       = pid_reg;
        raw_next       = raw_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        early_next     = early_reg;
        early_sts_next = early_sts_reg;
        fnd_start_next = fnd_start_reg;
        fnd_len_next   = fnd_len_reg;
        pos_next       = pos_reg;
        spare_next     = spare_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        free_ctl       = '{op: LIST_HOLD, data: '0, set_one: 1'b0};
        alloc_ctl      = '{op: LIST_HOLD, data: '0, set_one: 1'b0};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next      = func_t'(s_data.func);
                    pid_next       = s_data.owner_id;
                    raw_next       = raw_in;
                    found_next     = 1'b0;
                    full_next      = 1'b0;
                    early_next     = 1'b0;
                    early_sts_next = STS_BAD_SIZE;
                    pos_next       = 16'd0;
                    spare_next     = spare_in;
                    state_next     = S_FINISH;
                    unique case (func_t'(s_data.func))
                        FUNC_ALLOC: begin
                            if (raw_in == 16'd0 || raw_in[15]) begin
                                early_next = 1'b1;
                            end else if (free_cnt != '0) begin
                                step_next  = free_cnt;
                                state_next = S_PASS;
                            end
                        end
                        FUNC_FREE: begin
                            if (alloc_cnt != '0) begin
                                step_next  = alloc_cnt;
                                state_next = S_PASS;
                            end
                        end
                        FUNC_DEFRAG: begin
                            if (alloc_cnt == '0) begin
                                early_next     = 1'b1;
                                early_sts_next = STS_DEF_EMPTY;
                            end else if (spare_in != 16'd0 &&
                                         alloc_cnt == CW'(MAX_REGIONS)) begin
                                early_next     = 1'b1;
                                early_sts_next = STS_FULL;
                            end else begin
                                step_next  = alloc_cnt;
                                state_next = S_PASS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PASS: begin
                unique case (func_reg)
                    FUNC_ALLOC: begin
                        free_ctl = '{op: LIST_ROT, data: head, set_one: 1'b0};
                        if (!found_reg && head.length >= raw_reg) begin
                            found_next = 1'b1;
                            if (head.length != raw_reg && table_full) begin
                                full_next = 1'b1;
                            end else begin
                                free_ctl.op    = LIST_DROP;
                                fnd_start_next = head.start;
                                fnd_len_next   = head.length;
                            end
                        end
                    end
                    FUNC_FREE: begin
                        alloc_ctl = '{op: LIST_ROT, data: head, set_one: 1'b0};
                        if (!found_reg && head.owner == pid_reg) begin
                            found_next     = 1'b1;
                            alloc_ctl.op   = LIST_DROP;
                            fnd_start_next = head.start;
                            fnd_len_next   = head.length;
                        end
                    end
                    default: begin
                        alloc_ctl = '{op: LIST_ROT,
                                      data: '{start: pos_reg, length: head.length,
                                              owner: head.owner},
                                      set_one: 1'b0};
                        pos_next  = pos_reg + head.length;
                    end
                endcase
                step_next = step_reg - CW'(1);
                if (step_reg == CW'(1)) state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    state_next   = S_IDLE;
                    if (early_reg) begin
                        m_data_next.status = early_sts_reg;
                    end else begin
                        unique case (func_reg)
                            FUNC_ALLOC: begin
                                if (full_reg) begin
                                    m_data_next.status = STS_FULL;
                                end else if (found_reg) begin
                                    m_data_next = '{status: STS_EXACT,
                                                    region_address: fnd_start_reg,
                                                    region_size: raw_reg};
                                    if (fnd_len_reg != raw_reg) begin
                                        m_data_next.status = STS_SPLIT;
                                        free_ctl = '{op: LIST_PUSH,
                                                     data: '{start: fnd_start_reg + raw_reg,
                                                             length: fnd_len_reg - raw_reg,
                                                             owner: 16'd0},
                                                     set_one: 1'b0};
                                    end
                                    alloc_ctl = '{op: LIST_PUSH,
                                                  data: '{start: fnd_start_reg,
                                                          length: raw_reg, owner: pid_reg},
                                                  set_one: 1'b0};
                                    total_next = total_reg + raw_reg;
                                end else begin
                                    m_data_next.status = STS_NO_FIT;
                                end
                            end
                            FUNC_FREE: begin
                                if (found_reg) begin
                                    m_data_next = '{status: STS_FREED,
                                                    region_address: fnd_start_reg,
                                                    region_size: fnd_len_reg};
                                    free_ctl = '{op: LIST_PUSH,
                                                 data: '{start: fnd_start_reg,
                                                         length: fnd_len_reg, owner: 16'd0},
                                                 set_one: 1'b0};
                                    total_next = total_reg - fnd_len_reg;
                                end else begin
                                    m_data_next.status = STS_NO_OWNER;
                                end
                            end
                            FUNC_DEFRAG: begin
                                m_data_next = '{status: STS_DEFRAG, region_address: pos_reg,
                                                region_size: spare_reg};
                                free_ctl = '{op: LIST_SET,
                                             data: '{start: pos_reg, length: spare_reg,
                                                     owner: 16'd0},
                                             set_one: (spare_reg != 16'd0)};
                            end
                            default: begin
                                m_data_next = '{status: STS_INIT, region_address: 16'd0,
                                                region_size: units_reg};
                                free_ctl = '{op: LIST_SET,
                                             data: '{start: 16'd0, length: units_reg,
                                                     owner: 16'd0},
                                             set_one: 1'b1};
                                alloc_ctl  = '{op: LIST_SET, data: '0, set_one: 1'b0};
                                total_next = 16'd0;
                            end
                        endcase
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= 16'd0;
            units_reg   <= DefaultUnits;
            found_reg   <= 1'b0;
            full_reg    <= 1'b0;
            early_reg   <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            found_reg   <= found_next;
            full_reg    <= full_next;
            early_reg   <= early_next;
            step_reg    <= step_next;
            if (cfg_valid) units_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        pid_reg       <= pid_next;
        raw_reg       <= raw_next;
        early_sts_reg <= early_sts_next;
        fnd_start_reg <= fnd_start_next;
        fnd_len_reg   <= fnd_len_next;
        pos_reg       <= pos_next;
        spare_reg     <= spare_next;
        m_data_reg    <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, free_cnt} + {1'b0, alloc_cnt}) <= (CW+1)'(MAX_REGIONS))
        else $error("region count exceeds table size");
    a_pass_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PASS) |-> (step_reg != '0))
        else $error("pass running with zero steps");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command taken while busy");
    a_full_found: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> found_reg)
        else $error("table full without fitting region");
`endif

endmodule

[sv/ffa_cell.sv]
module ffa_cell #(
    parameter ffa_pkg::entry_t RST_VAL = '0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffa_pkg::cell_op_t op,
    input  ffa_pkg::entry_t   left_in,
    input  ffa_pkg::entry_t   right_in,
    input  ffa_pkg::entry_t   load_in,
    output ffa_pkg::entry_t   q
);
    import ffa_pkg::*;

    entry_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= RST_VAL;
        end else begin
            unique case (op)
                CELL_HOLD:  data_reg <= data_reg;
                CELL_RIGHT: data_reg <= right_in;
                CELL_LEFT:  data_reg <= left_in;
                CELL_LOAD:  data_reg <= load_in;
                default:    data_reg <= data_reg;
            endcase
        end
    end

    assign q = data_reg;

endmodule

[sv/ffa_list.sv]
module ffa_list #(
    parameter int              MAX_REGIONS = ffa_pkg::MaxRegions,
    parameter bit              RST_ONE     = 1'b0,
    parameter ffa_pkg::entry_t RST_ENTRY   = '0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ffa_pkg::list_ctl_t               ctl,
    output ffa_pkg::entry_t                  head,
    output logic [$clog2(MAX_REGIONS+1)-1:0] count
);
    import ffa_pkg::*;

    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    entry_t        q      [MAX_REGIONS];
    cell_op_t      cop    [MAX_REGIONS];

    always_comb begin
        unique case (ctl.op)
            LIST_DROP: count_next = count_reg - CW'(1);
            LIST_PUSH: count_next = count_reg + CW'(1);
            LIST_SET:  count_next = CW'(ctl.set_one);
            default:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(RST_ONE);
        end else begin
            count_reg <= count_next;
        end
    end

    for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
        entry_t left_w;
        entry_t right_w;

        if (k == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid
            assign left_w = q[k-1];
        end
        if (k == MAX_REGIONS - 1) begin : g_last
            assign right_w = q[k];
        end else begin : g_body
            assign right_w = q[k+1];
        end

        always_comb begin
            unique case (ctl.op)
                LIST_ROT: begin
                    if (CW'(k + 1) < count_reg) cop[k] = CELL_RIGHT;
                    else if (CW'(k + 1) == count_reg) cop[k] = CELL_LOAD;
                    else cop[k] = CELL_HOLD;
                end
                LIST_DROP: cop[k] = CELL_RIGHT;
                LIST_PUSH: cop[k] = (k == 0) ? CELL_LOAD : CELL_LEFT;
                LIST_SET:  cop[k] = (k == 0) ? CELL_LOAD : CELL_HOLD;
                default:   cop[k] = CELL_HOLD;
            endcase
        end

        ffa_cell #(
            .RST_VAL(RST_ENTRY)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (cop[k]),
            .left_in (left_w),
            .right_in(right_w),
            .load_in (ctl.data),
            .q       (q[k])
        );
    end

    assign head  = q[0];
    assign count = count_reg;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ffa_pkg::*;

    localparam int Slots = MaxRegions;
    localparam int StallLimit = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = '0;

    first_fit_allocator_with_compaction i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // model of the region table
    logic [15:0] units;
    logic [15:0] reg_start [Slots];
    logic [15:0] reg_len [Slots];
    logic [15:0] reg_owner [Slots];
    int free_list [$];
    int alloc_list [$];
    logic [15:0] alloc_sum;

    rsp_t expected_rsp [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int mismatches = 0;
    int accepted_cmds = 0;
    int accepted_rsps = 0;
    int quiet_cycles = 0;
    int status_hits [16];
    logic [15:0] pid_pool [4] = '{16'h0001, 16'h00a5, 16'hffff, 16'h0000};

    function automatic void table_init();
        for (int i = 0; i < Slots; i++) begin
            reg_start[i] = '0;
            reg_len[i] = '0;
            reg_owner[i] = '0;
        end
        reg_len[0] = units;
        free_list = '{0};
        alloc_list = {};
        alloc_sum = '0;
    endfunction

    function automatic int spare_slot();
        bit used [Slots];
        foreach (free_list[i]) used[free_list[i]] = 1'b1;
        foreach (alloc_list[i]) used[alloc_list[i]] = 1'b1;
        for (int i = 0; i < Slots; i++) begin
            if (!used[i]) return i;
        end
        return Slots;
    endfunction

    function automatic rsp_t allocator_step(req_t cmd);
        rsp_t r;
        logic [15:0] want;
        int s, slot;
        logic [16:0] spare;
        logic [15:0] pos;
        r = '0;
        want = cmd.request_size;
        case (func_t'(cmd.func))
            FUNC_ALLOC: begin
                if (want == 0 || want[15]) begin
                    r.status = STS_BAD_SIZE;
                end else begin
                    r.status = STS_NO_FIT;
                    for (int i = 0; i < free_list.size(); i++) begin
                        slot = free_list[i];
                        if (reg_len[slot] < want) continue;
                        if (reg_len[slot] > want) begin
                            s = spare_slot();
                            if (s >= Slots) begin
                                r.status = STS_FULL;
                                break;
                            end
                            free_list.delete(i);
                            reg_start[s] = reg_start[slot] + want;
                            reg_len[s] = reg_len[slot] - want;
                            reg_owner[s] = '0;
                            free_list.push_front(s);
                            reg_len[slot] = want;
                            r.status = STS_SPLIT;
                        end else begin
                            free_list.delete(i);
                            r.status = STS_EXACT;
                        end
                        reg_owner[slot] = cmd.owner_id;
                        alloc_list.push_front(slot);
                        alloc_sum = alloc_sum + want;
                        r.region_address = reg_start[slot];
                        r.region_size = want;
                        break;
                    end
                end
            end
            FUNC_FREE: begin
                r.status = STS_NO_OWNER;
                for (int i = 0; i < alloc_list.size(); i++) begin
                    slot = alloc_list[i];
                    if (reg_owner[slot] != cmd.owner_id) continue;
                    alloc_list.delete(i);
                    alloc_sum = alloc_sum - reg_len[slot];
                    reg_owner[slot] = '0;
                    if (free_list.size() < Slots) free_list.push_front(slot);
                    r.status = STS_FREED;
                    r.region_address = reg_start[slot];
                    r.region_size = reg_len[slot];
                    break;
                end
            end
            FUNC_DEFRAG: begin
                if (alloc_list.size() == 0) begin
                    r.status = STS_DEF_EMPTY;
                end else begin
                    spare = (alloc_sum < units) ? units - alloc_sum : 0;
                    if (spare > 0 && alloc_list.size() >= Slots) begin
                        r.status = STS_FULL;
                    end else begin
                        pos = '0;
                        foreach (alloc_list[i]) begin
                            reg_start[alloc_list[i]] = pos;
                            pos = pos + reg_len[alloc_list[i]];
                        end
                        free_list = {};
                        if (spare > 0) begin
                            s = spare_slot();
                            reg_start[s] = pos;
                            reg_len[s] = spare[15:0];
                            reg_owner[s] = '0;
                            free_list.push_front(s);
                        end
                        r.status = STS_DEFRAG;
                        r.region_address = pos;
                        r.region_size = spare[15:0];
                    end
                end
            end
            default: begin
                table_init();
                r.status = STS_INIT;
                r.region_size = units;
            end
        endcase
        return r;
    endfunction

    task automatic send_cmd(func_t f, logic [15:0] pid, logic [15:0] size);
        req_t cmd;
        cmd.func = f;
        cmd.owner_id = pid;
        cmd.request_size = size;
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_rsp.push_back(allocator_step(cmd));
        accepted_cmds++;
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_rsp.size() != 0) @(posedge aclk);
        repeat (4 * Slots) @(posedge aclk);
    endtask

    task automatic write_units(logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        units = value;
    endtask

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            accepted_rsps++;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                if (m_data !== expected_rsp[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", expected_rsp[0], m_data);
                end
                status_hits[expected_rsp[0].status]++;
                void'(expected_rsp.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic random_cmd(int alloc_max);
        int pick;
        logic [15:0] pid;
        pick = $urandom_range(99);
        pid = ($urandom_range(3) == 0) ? 16'($urandom) : pid_pool[$urandom_range(3)];
        if (pick < 50)
            send_cmd(FUNC_ALLOC, pid, ($urandom_range(9) == 0) ? 16'($urandom)
                                    : 16'($urandom_range(alloc_max, 1)));
        else if (pick < 85) send_cmd(FUNC_FREE, pid, 16'($urandom));
        else if (pick < 96) send_cmd(FUNC_DEFRAG, 16'($urandom), 16'($urandom));
        else send_cmd(FUNC_INIT, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        send_cmd(FUNC_DEFRAG, 16'h0000, 16'h0000);
        send_cmd(FUNC_ALLOC, 16'h0001, 16'h0000);
        send_cmd(FUNC_ALLOC, 16'h0001, 16'h8000);
        send_cmd(FUNC_ALLOC, 16'h0001, 16'hffff);
        send_cmd(FUNC_ALLOC, 16'h0001, 16'h7fff);
        send_cmd(FUNC_ALLOC, 16'hffff, 16'd100);
        send_cmd(FUNC_ALLOC, 16'h0000, 16'd1);
        send_cmd(FUNC_ALLOC, 16'h00a5, 16'd899);
        send_cmd(FUNC_FREE, 16'h1234, 16'h0000);
        send_cmd(FUNC_FREE, 16'hffff, 16'h0000);
        send_cmd(FUNC_DEFRAG, 16'h0000, 16'h0000);
        send_cmd(FUNC_FREE, 16'h0000, 16'h0000);
        send_cmd(FUNC_FREE, 16'h00a5, 16'h0000);
        send_cmd(FUNC_INIT, 16'hffff, 16'hffff);
        for (int i = 0; i < 17; i++) send_cmd(FUNC_ALLOC, 16'(i), 16'd10);
        send_cmd(FUNC_FREE, 16'd3, 16'h0000);
        send_cmd(FUNC_DEFRAG, 16'h0000, 16'h0000);
        send_cmd(FUNC_INIT, 16'h0000, 16'h0000);
    endtask

    task automatic test_full_table();
        send_cmd(FUNC_INIT, 16'h0000, 16'h0000);
        for (int i = 0; i < 16; i++) send_cmd(FUNC_ALLOC, 16'(i), 16'd5);
        send_cmd(FUNC_DEFRAG, 16'h0000, 16'h0000);
        send_cmd(FUNC_FREE, 16'd7, 16'h0000);
        send_cmd(FUNC_DEFRAG, 16'h0000, 16'h0000);
    endtask

    task automatic test_config_extremes();
        write_units(16'd0);
        send_cmd(FUNC_INIT, 16'h0000, 16'h0000);
        send_cmd(FUNC_ALLOC, 16'h0001, 16'd1);
        write_units(16'hffff);
        send_cmd(FUNC_INIT, 16'h0000, 16'h0000);
        send_cmd(FUNC_ALLOC, 16'h0001, 16'h7fff);
        send_cmd(FUNC_ALLOC, 16'h0002, 16'h7fff);
        send_cmd(FUNC_ALLOC, 16'h0003, 16'd1);
        send_cmd(FUNC_DEFRAG, 16'h0000, 16'h0000);
        write_units(16'd1);
        send_cmd(FUNC_DEFRAG, 16'h0000, 16'h0000);
        send_cmd(FUNC_INIT, 16'h0000, 16'h0000);
        send_cmd(FUNC_ALLOC, 16'h0001, 16'd1);
    endtask

    task automatic test_random(int count);
        int alloc_max;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                case ((i / 150) % 3)
                    0: write_units(16'($urandom_range(400, 50)));
                    1: write_units(16'($urandom));
                    default: write_units(DefaultUnits);
                endcase
                send_cmd(FUNC_INIT, 16'h0000, 16'h0000);
            end
            alloc_max = (units > 1) ? units / 6 + 1 : 2;
            random_cmd(alloc_max);
        end
    endtask

    task automatic test_backpressure();
        hold_off <= 400;
        for (int i = 0; i < 30; i++) random_cmd(80);
        drain();
        for (int i = 0; i < 10; i++) random_cmd(80);
    endtask

    initial begin
        units = DefaultUnits;
        table_init();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 34;
        recv_idle_pct = 76;
        test_directed();
        test_full_table();
        test_config_extremes();
        test_random(330);
        send_idle_pct = 76;
        recv_idle_pct = 34;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(300);
        drain();
        repeat (50) @(posedge aclk);
        $display("Ran %0d commands, %0d results checked; splits %0d, exact %0d, frees %0d,",
                 accepted_cmds, accepted_rsps, status_hits[STS_SPLIT],
                 status_hits[STS_EXACT], status_hits[STS_FREED]);
        $display("defrags %0d, table full %0d, no fit %0d, bad size %0d.",
                 status_hits[STS_DEFRAG], status_hits[STS_FULL],
                 status_hits[STS_NO_FIT], status_hits[STS_BAD_SIZE]);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[sim.f]
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/ffa_list.sv
sv/first_fit_allocator_with_compaction.sv
sim/testbench.sv
